@@ rtl/itp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the infix-to-postfix converter: item types, sequencer states,
// character constants and the operator precedence function. No dependencies.

package itp_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	typedef struct packed {
		logic [7:0] symbol;
		logic       expr_end;
	} infix_item_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       run_last;
		logic       expr_done;
		logic       overflow_seen;
	} postfix_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP_RD,
		ST_OP_CMP,
		ST_PUSH,
		ST_FLUSH_RD,
		ST_FLUSH_POP,
		ST_FINISH
	} itp_state_t;

	// Lowercase letters are operands and go straight to the output.
	function automatic logic is_letter(logic [7:0] ch);
		return (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
	endfunction

	// True when the stacked character must be popped before the incoming one
	// is pushed. The caret is right associative, so it never pops another caret.
	function automatic logic top_precedes(logic [7:0] top, logic [7:0] sym);
		logic high_top;
		logic low_top;
		logic low_sym;
		high_top = (top == CH_CARET) || (top == CH_STAR) ||
			(top == CH_SLASH) || (top == CH_PERCENT);
		low_top  = (top == CH_PLUS) || (top == CH_MINUS);
		low_sym  = (sym == CH_PLUS) || (sym == CH_MINUS);
		if (high_top)
			return sym != CH_CARET;
		else if (low_top)
			return low_sym;
		else
			return 1'b0;
	endfunction

endpackage

@@ rtl/infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps
// Top level of the infix-to-postfix converter (shunting yard, no parentheses).
// Depends on itp_pkg and itp_stack_ram.
//
// Usage: the infix channel carries one character per item, with expr_end set on
// the final character of an expression. The postfix channel returns the postfix
// characters; run_last marks the last result caused by an input item, expr_done
// the final character of the expression, and overflow_seen reports whether an
// operator was dropped on a full stack earlier in the expression.
// The block works on one item at a time and raises infix_stall until that item
// is finished. An operator pops the stack entries that precede it and is then
// pushed, each comparison waiting on the registered read of the stack RAM. An
// end item then flushes the remaining stack entries.
// Results leave through an output register, so a new item is accepted while
// the last result still waits; a stalled receiver holds the sequencer whenever
// a new result has to pass that register. Each result is held back one step
// inside the block until it is known whether another follows it; a letter
// is offered only after passing the held-back and the output registers.
// Reset clears the stack count, the overflow flag and all valid bits; the stack
// RAM itself is not cleared, since only written entries are ever read.

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  infix_valid,
	output logic                  infix_stall,
	input  itp_pkg::infix_item_t  infix,
	output logic                  postfix_valid,
	input  logic                  postfix_stall,
	output itp_pkg::postfix_item_t postfix
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	itp_pkg::itp_state_t state_q, state_nxt;

	// Item under work.
	logic [7:0] sym_q;
	logic       end_q;

	// Stack bookkeeping.
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_m1;
	logic          ovf_q;
	logic          stack_full;

	// Held-back result: it is released once the next result or the end of the
	// item tells whether it is the last one.
	logic       pend_valid_q;
	logic [7:0] pend_sym_q;
	logic       pend_ovf_q;

	// Output register.
	logic                   out_valid_q;
	itp_pkg::postfix_item_t out_q;
	logic                   out_free;

	// RAM interface.
	logic          ram_wr_en;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic [AW-1:0] ram_wr_addr;
	logic [7:0]    ram_rd_data;

	// Sequencer controls.
	logic       accept;
	logic       can_pend;
	logic       pop_ok;
	logic       pend_load;
	logic       pend_shift;
	logic       pend_final;
	logic [7:0] pend_data;
	logic       cnt_inc;
	logic       cnt_dec;
	logic       set_ovf;
	logic       done_go;

	itp_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (sym_q),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign infix_stall = (state_q != itp_pkg::ST_IDLE);
	assign accept      = infix_valid && !infix_stall;

	assign count_m1    = count_q - {{(CW-1){1'b0}}, 1'b1};
	assign ram_rd_addr = count_m1[AW-1:0];
	assign ram_wr_addr = count_q[AW-1:0];
	assign stack_full  = (count_q >= CW'(STACK_DEPTH));

	// The output register can take a result when it is empty or being drained.
	assign out_free = !out_valid_q || !postfix_stall;
	// A new result can be held back when the held one can move on.
	assign can_pend = !pend_valid_q || out_free;
	assign pop_ok   = itp_pkg::top_precedes(ram_rd_data, sym_q);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			itp_pkg::ST_IDLE: begin
				if (accept) begin
					if (itp_pkg::is_letter(infix.symbol))
						state_nxt = infix.expr_end ? itp_pkg::ST_FLUSH_RD : itp_pkg::ST_FINISH;
					else if (count_q != '0)
						state_nxt = itp_pkg::ST_OP_RD;
					else
						state_nxt = itp_pkg::ST_PUSH;
				end
			end
			itp_pkg::ST_OP_RD: begin
				state_nxt = itp_pkg::ST_OP_CMP;
			end
			itp_pkg::ST_OP_CMP: begin
				if (!pop_ok)
					state_nxt = itp_pkg::ST_PUSH;
				else if (can_pend)
					state_nxt = (count_m1 != '0) ? itp_pkg::ST_OP_RD : itp_pkg::ST_PUSH;
			end
			itp_pkg::ST_PUSH: begin
				state_nxt = end_q ? itp_pkg::ST_FLUSH_RD : itp_pkg::ST_FINISH;
			end
			itp_pkg::ST_FLUSH_RD: begin
				state_nxt = (count_q != '0) ? itp_pkg::ST_FLUSH_POP : itp_pkg::ST_FINISH;
			end
			itp_pkg::ST_FLUSH_POP: begin
				if (can_pend)
					state_nxt = itp_pkg::ST_FLUSH_RD;
			end
			itp_pkg::ST_FINISH: begin
				if (can_pend)
					state_nxt = itp_pkg::ST_IDLE;
			end
			default: state_nxt = itp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ram_wr_en  = 1'b0;
		ram_rd_en  = 1'b0;
		pend_load  = 1'b0;
		pend_shift = 1'b0;
		pend_final = 1'b0;
		pend_data  = ram_rd_data;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		set_ovf    = 1'b0;
		done_go    = 1'b0;
		unique case (state_q)
			itp_pkg::ST_IDLE: begin
				// Nothing is held back while idle, so a letter loads directly.
				if (accept && itp_pkg::is_letter(infix.symbol)) begin
					pend_load = 1'b1;
					pend_data = infix.symbol;
				end
			end
			itp_pkg::ST_OP_RD: begin
				ram_rd_en = 1'b1;
			end
			itp_pkg::ST_OP_CMP: begin
				if (pop_ok && can_pend) begin
					pend_load  = 1'b1;
					pend_shift = pend_valid_q;
					cnt_dec    = 1'b1;
				end
			end
			itp_pkg::ST_PUSH: begin
				if (stack_full) begin
					set_ovf = 1'b1;
				end else begin
					ram_wr_en = 1'b1;
					cnt_inc   = 1'b1;
				end
			end
			itp_pkg::ST_FLUSH_RD: begin
				ram_rd_en = (count_q != '0);
			end
			itp_pkg::ST_FLUSH_POP: begin
				if (can_pend) begin
					pend_load  = 1'b1;
					pend_shift = pend_valid_q;
					cnt_dec    = 1'b1;
				end
			end
			itp_pkg::ST_FINISH: begin
				if (can_pend) begin
					done_go    = 1'b1;
					pend_final = pend_valid_q;
				end
			end
			default: begin
				done_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= itp_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= infix.symbol;
			end_q <= infix.expr_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (done_go && end_q) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cnt_inc)
					count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
				else if (cnt_dec)
					count_q <= count_m1;
				if (set_ovf)
					ovf_q <= 1'b1;
			end
		end
	end

	// Held-back result. Its overflow bit is the flag at the time it is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_valid_q <= 1'b0;
		else if (pend_load)
			pend_valid_q <= 1'b1;
		else if (pend_final)
			pend_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_sym_q <= pend_data;
			pend_ovf_q <= ovf_q;
		end
	end

	// Output register: a held result moves here either because a newer one
	// follows it or because the item is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pend_shift || pend_final)
			out_valid_q <= 1'b1;
		else if (!postfix_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pend_shift || pend_final) begin
			out_q.out_symbol    <= pend_sym_q;
			out_q.run_last      <= pend_final;
			out_q.expr_done     <= pend_final && end_q;
			out_q.overflow_seen <= pend_ovf_q;
		end
	end

	assign postfix_valid = out_valid_q;
	assign postfix       = out_q;

endmodule

@@ rtl/itp_stack_ram.sv @@
`timescale 1ns / 1ps
// Operator stack storage: single-port-write, single-port-read synchronous RAM
// with registered read data. Standalone; no package dependency.

module itp_stack_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Read data holds its value until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/itp_port_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the infix-to-postfix converter, bound to the top level.
// Depends on itp_pkg for the item types.

module itp_port_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   infix_valid,
	input logic                   infix_stall,
	input itp_pkg::infix_item_t   infix,
	input logic                   postfix_valid,
	input logic                   postfix_stall,
	input itp_pkg::postfix_item_t postfix
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		postfix_valid && postfix_stall |=> postfix_valid && $stable(postfix))
		else $error("stalled postfix item changed or vanished");

	// The end of an expression is always the last result of its item.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		postfix_valid && postfix.expr_done |-> postfix.run_last)
		else $error("expr_done without run_last");

	// One item is worked on at a time: after an accept the input is stalled.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		infix_valid && !infix_stall |=> infix_stall)
		else $error("input not stalled after an accepted item");

	// An accepted end item keeps the input stalled while the stack is flushed
	// and the item finishes.
	a_letter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		infix_valid && !infix_stall && infix.expr_end |=> infix_stall ##1 infix_stall)
		else $error("end item finished too early");

endmodule

bind infix_to_postfix_converter itp_port_checker u_itp_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.infix_valid   (infix_valid),
	.infix_stall   (infix_stall),
	.infix         (infix),
	.postfix_valid (postfix_valid),
	.postfix_stall (postfix_stall),
	.postfix       (postfix)
);

@@ test/infix_to_postfix_checker.sv @@
`timescale 1ns / 1ps
// Checker for the infix-to-postfix converter: watches both channels, predicts
// the postfix items and compares them field by field. Depends on itp_pkg.

module infix_to_postfix_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   infix_valid,
	input  logic                   infix_stall,
	input  itp_pkg::infix_item_t   infix,
	input  logic                   postfix_valid,
	input  logic                   postfix_stall,
	input  itp_pkg::postfix_item_t postfix,
	output int                     fail_count,
	output int                     pending_count
);

	localparam int DEPTH = itp_pkg::STACK_DEPTH_DEF;

	logic [7:0]             op_stack [DEPTH];
	int                     op_count;
	logic                   dropped_op;
	itp_pkg::postfix_item_t postfix_q [$];

	// Binding strength: 2 for the multiplicative group and caret, 1 for plus
	// and minus, 0 for any other byte.
	function automatic int binding_of(logic [7:0] ch);
		case (ch)
			itp_pkg::CH_CARET, itp_pkg::CH_STAR, itp_pkg::CH_SLASH,
			itp_pkg::CH_PERCENT: return 2;
			itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic pops_for(logic [7:0] top, logic [7:0] sym);
		int top_binding;
		top_binding = binding_of(top);
		if (top_binding == 2)
			return sym != itp_pkg::CH_CARET;
		return (top_binding == 1) && (binding_of(sym) == 1);
	endfunction

	function automatic itp_pkg::postfix_item_t postfix_of(logic [7:0] ch);
		itp_pkg::postfix_item_t res;
		res = '0;
		res.out_symbol = ch;
		res.overflow_seen = dropped_op;
		return res;
	endfunction

	// Runs one infix item through the shunting yard and queues what it emits.
	function automatic void convert_item(itp_pkg::infix_item_t item);
		itp_pkg::postfix_item_t run [$];
		if (item.symbol >= itp_pkg::CH_LOWER_A && item.symbol <= itp_pkg::CH_LOWER_Z) begin
			run.push_back(postfix_of(item.symbol));
		end else begin
			while (op_count > 0 && pops_for(op_stack[op_count - 1], item.symbol)) begin
				op_count--;
				run.push_back(postfix_of(op_stack[op_count]));
			end
			if (op_count >= DEPTH) begin
				dropped_op = 1'b1;
			end else begin
				op_stack[op_count] = item.symbol;
				op_count++;
			end
		end
		if (item.expr_end) begin
			while (op_count > 0) begin
				op_count--;
				run.push_back(postfix_of(op_stack[op_count]));
			end
			if (run.size() > 0)
				run[run.size() - 1].expr_done = 1'b1;
			dropped_op = 1'b0;
		end
		if (run.size() > 0)
			run[run.size() - 1].run_last = 1'b1;
		foreach (run[i])
			postfix_q.push_back(run[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		itp_pkg::postfix_item_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			op_count = 0;
			dropped_op = 1'b0;
			postfix_q.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (infix_valid && !infix_stall)
				convert_item(infix);
			if (postfix_valid && !postfix_stall) begin
				if (postfix_q.size() == 0) begin
					$error("postfix item %h arrived with nothing expected", postfix);
					errs++;
				end else begin
					want = postfix_q.pop_front();
					if (postfix.out_symbol !== want.out_symbol) begin
						$error("out_symbol: expected %h, actual %h",
							want.out_symbol, postfix.out_symbol);
						errs++;
					end
					if (postfix.run_last !== want.run_last) begin
						$error("run_last: expected %b, actual %b",
							want.run_last, postfix.run_last);
						errs++;
					end
					if (postfix.expr_done !== want.expr_done) begin
						$error("expr_done: expected %b, actual %b",
							want.expr_done, postfix.expr_done);
						errs++;
					end
					if (postfix.overflow_seen !== want.overflow_seen) begin
						$error("overflow_seen: expected %b, actual %b",
							want.overflow_seen, postfix.overflow_seen);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending_count <= postfix_q.size();
		end
	end

endmodule

@@ test/infix_to_postfix_converter_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the infix-to-postfix converter: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on itp_pkg and the checker module.

module infix_to_postfix_converter_test;

	// The slowest item pops a full stack and then flushes it. Some 290 items
	// with such items, stalls and gaps stay far below this limit.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 200;
	localparam int RANDOM_ITEMS = 250;
	localparam int DRAIN_CYCLES = 80;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   infix_valid;
	logic                   infix_stall;
	itp_pkg::infix_item_t   infix;
	logic                   postfix_valid;
	logic                   postfix_stall;
	itp_pkg::postfix_item_t postfix;

	int fail_count;
	int pending_count;
	int items_sent = 0;
	int cycle_count = 0;

	// Idling switches, cleared together for a stretch with no gaps at all.
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	// The stimulus asks for a long receiver hold by bumping hold_requests; the
	// receiver process serves it and bumps hold_served, so each has one writer.
	int hold_requests = 0;
	int hold_served;

	logic [7:0] operators [6] = '{itp_pkg::CH_CARET, itp_pkg::CH_STAR, itp_pkg::CH_SLASH,
		itp_pkg::CH_PERCENT, itp_pkg::CH_PLUS, itp_pkg::CH_MINUS};

	always #4 clk = ~clk;

	infix_to_postfix_converter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.infix_valid   (infix_valid),
		.infix_stall   (infix_stall),
		.infix         (infix),
		.postfix_valid (postfix_valid),
		.postfix_stall (postfix_stall),
		.postfix       (postfix)
	);

	infix_to_postfix_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.infix_valid   (infix_valid),
		.infix_stall   (infix_stall),
		.infix         (infix),
		.postfix_valid (postfix_valid),
		.postfix_stall (postfix_stall),
		.postfix       (postfix),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Offers one item and returns at the edge where it is accepted. A random
	// gap may come first; valid then drops until a later clock edge, so it
	// is never lowered and raised within one time step. While stalled, the
	// payload stays as it is.
	task automatic send_item(input logic [7:0] sym, input logic last);
		if (tx_idle_en && $urandom_range(99) < 11) begin
			infix_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		infix_valid <= 1'b1;
		infix <= '{symbol: sym, expr_end: last};
		@(posedge clk);
		while (infix_stall) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [7:0] any_letter();
		return 8'($urandom_range(itp_pkg::CH_LOWER_Z, itp_pkg::CH_LOWER_A));
	endfunction

	// Mostly one of the six operators, now and then any byte at all.
	function automatic logic [7:0] any_operator();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return operators[$urandom_range(5)];
	endfunction

	// A well-formed expression: letter, then operator and letter pairs, with
	// the end flag on the final letter.
	task automatic send_expression(input int operands);
		for (int i = 0; i < operands; i++) begin
			if (i > 0)
				send_item(any_operator(), 1'b0);
			send_item(any_letter(), i == operands - 1);
		end
	endtask

	// A run of symbols that never pop each other: all carets (right
	// associative) or all digits (no precedence). Long runs fill the stack,
	// so later symbols are dropped and the overflow flag rises.
	task automatic send_stack_run(input int run_len);
		logic [7:0] fill;
		fill = $urandom_range(1) ? itp_pkg::CH_CARET : 8'($urandom_range(8'h39, 8'h30));
		repeat (run_len) send_item(fill, 1'b0);
		send_item($urandom_range(1) ? any_letter() : fill, 1'b1);
	endtask

	// Receiver: random single-cycle stalls, none while rx_idle_en is clear,
	// and one long hold on request that lets the block back up into its input.
	initial begin
		postfix_stall = 1'b0;
		hold_served = 0;
		@(posedge clk);
		forever begin
			if (hold_requests != hold_served) begin
				postfix_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end else begin
				postfix_stall <= rx_idle_en && ($urandom_range(99) < 11);
				@(posedge clk);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [7:0] mixed [8];
		int random_base;
		int kind;
		bit paused;
		mixed = '{itp_pkg::CH_LOWER_A, itp_pkg::CH_MINUS, itp_pkg::CH_LOWER_Z,
			itp_pkg::CH_STAR, 8'h00, itp_pkg::CH_PERCENT, itp_pkg::CH_SLASH, 8'hFF};
		paused = 1'b0;
		arst_n = 1'b0;
		infix_valid = 1'b0;
		infix = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Seventeen carets stack up without popping, since the
		// caret is right associative; the last one meets a full stack and is
		// dropped. A plus with the end flag then pops all sixteen and flushes
		// itself, which is the longest run of results one item can cause, all
		// of them carrying the overflow mark.
		repeat (17) send_item(itp_pkg::CH_CARET, 1'b0);
		send_item(itp_pkg::CH_PLUS, 1'b1);
		// Both letter bounds, the remaining operators, and the bytes 00 and FF
		// that are pushed as operators with no precedence of their own.
		foreach (mixed[i])
			send_item(mixed[i], i == 7);

		// Random part. It opens with the long receiver hold while the sender
		// keeps offering, so the block fills up and stalls its input.
		random_base = items_sent;
		hold_requests++;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			// A stretch of about sixty items with no idling on either side.
			tx_idle_en = !(items_sent - random_base inside {[100:160]});
			rx_idle_en = tx_idle_en;
			// Once, the sender waits until every expected item has come back.
			if (!paused && items_sent - random_base >= 200) begin
				paused = 1'b1;
				infix_valid <= 1'b0;
				do @(posedge clk); while (pending_count != 0);
			end
			kind = $urandom_range(99);
			if (kind < 72) begin
				send_expression($urandom_range(6, 1));
			end else if (kind < 82) begin
				send_stack_run($urandom_range(20, 10));
			end else begin
				// Noise: any byte, with the end flag now and then.
				repeat ($urandom_range(8, 1))
					send_item(8'($urandom_range(255)), $urandom_range(5) == 0);
			end
		end

		// Drain: wait for every expected item, then give the block time to
		// show any stray item before the verdict.
		infix_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ infix_to_postfix_converter.f @@
rtl/itp_pkg.sv
rtl/itp_stack_ram.sv
rtl/infix_to_postfix_converter.sv
rtl/itp_port_checker.sv
test/infix_to_postfix_checker.sv
test/infix_to_postfix_converter_test.sv
